// ----- rtl/core/ils_pkg.sv -----
// ils_pkg: shared constants for the indexed list store
// operation codes, status codes and field widths of the stream beats
// no dependencies
package ils_pkg;

   // field widths of the work items
   localparam int OP_W     = 2;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int LEN_W    = 7;

   // stream beat widths, tdata padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = OP_W;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = STATUS_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_READ   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

// ----- rtl/core/ils_ram.sv -----
// ils_ram: generic simple dual-port ram, one write and one read port
// read data is registered; no dependencies
module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/indexed_list_store_top.sv -----
// indexed_list_store_top: ordered list of signed 32-bit values with read, insert, delete
// one item at a time: a new request is taken only while idle; shifts move one entry at a time
// (a read, then a write) through the single ram port pair and the shared address stepper.
// synchronous reset clears the state, the entry count and the response valid only; list
// contents are undefined until written and need no clearing pass
module indexed_list_store_top #(
   parameter int CAPACITY = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // request beat
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ils_pkg::REQ_DATA_W-1:0]    req_tdata,  // position[6:0], value[38:7], zero pad
   input  logic [ils_pkg::REQ_USER_W-1:0]    req_tuser,  // op[1:0]
   // response beat
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ils_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // read_value[31:0], length[38:32], zero pad
   output logic [ils_pkg::RSP_USER_W-1:0]    rsp_tuser   // status[1:0]
);

   import ils_pkg::*;

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int AW   = $clog2(CAPACITY);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SH_RD  = 5'b00010,
      S_SH_WR  = 5'b00100,
      S_PUT    = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  rd_hit_ff, rd_hit_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [VALUE_W-1:0]    val_ff, val_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [AW-1:0]         wr_addr_ff, wr_addr_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]      rsp_len_ff, rsp_len_in;

   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
   logic [VALUE_W-1:0]    ram_wr_data, ram_rd_data;

   logic                  unit_up;
   logic [AW-1:0]         unit_out;

   logic [POS_W-1:0]      req_pos;
   logic [CMPW-1:0]       pos_ext, pos_p1, count_ext, cnt_m1, count_next_ext;
   logic                  accept, slot_free, is_insert;

   assign req_pos   = req_tdata[POS_W-1:0];
   assign pos_ext   = CMPW'(req_pos);
   assign pos_p1    = pos_ext + CMPW'(1);
   assign count_ext = CMPW'(count_ff);
   assign cnt_m1    = count_ext - CMPW'(1);
   assign accept    = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign is_insert = (op_ff == OP_INSERT);

   // shared address stepper
   assign unit_out = unit_up ? addr_ff + AW'(1) : addr_ff - AW'(1);

   // list storage
   ils_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      rd_hit_in     = rd_hit_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      addr_in       = addr_ff;
      wr_addr_in    = wr_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_wr_addr   = wr_addr_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = addr_ff;
      unit_up       = 1'b0;
      count_next_ext = count_ext;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_tuser;
               pos_in    = pos_ext[AW-1:0];
               val_in    = req_tdata[POS_W +: VALUE_W];
               rd_hit_in = 1'b0;
               status_in = STATUS_DONE;
               state_in  = S_FINISH;
               case (req_tuser)
                  OP_READ: begin
                     if (pos_ext < count_ext) begin
                        ram_re      = 1'b1;
                        ram_rd_addr = pos_ext[AW-1:0];
                        rd_hit_in   = 1'b1;
                     end else begin
                        status_in = STATUS_RANGE;
                     end
                  end
                  OP_INSERT: begin
                     if (pos_ext > count_ext) begin
                        status_in = STATUS_RANGE;
                     end else if (count_ext == CMPW'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else if (pos_ext == count_ext) begin
                        state_in = S_PUT;
                     end else begin
                        addr_in  = cnt_m1[AW-1:0];
                        state_in = S_SH_RD;
                     end
                  end
                  OP_DELETE: begin
                     if (pos_ext >= count_ext) begin
                        status_in = STATUS_RANGE;
                     end else if (pos_p1 != count_ext) begin
                        addr_in  = pos_p1[AW-1:0];
                        state_in = S_SH_RD;
                     end
                  end
                  default: begin
                     status_in = STATUS_DONE;
                  end
               endcase
            end
         end
         // fetch the entry to move, step to its new place
         S_SH_RD: begin
            ram_re      = 1'b1;
            ram_rd_addr = addr_ff;
            unit_up     = is_insert;
            wr_addr_in  = unit_out;
            state_in    = S_SH_WR;
         end
         // store the moved entry, step to the next source
         S_SH_WR: begin
            ram_we      = 1'b1;
            ram_wr_addr = wr_addr_ff;
            ram_wr_data = ram_rd_data;
            unit_up     = !is_insert;
            addr_in     = unit_out;
            if (is_insert) begin
               state_in = (addr_ff == pos_ff) ? S_PUT : S_SH_RD;
            end else begin
               state_in = (CMPW'(addr_ff) == cnt_m1) ? S_FINISH : S_SH_RD;
            end
         end
         // place the inserted value
         S_PUT: begin
            ram_we      = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = val_ff;
            state_in    = S_FINISH;
         end
         // update count and load the response register
         S_FINISH: begin
            if (status_ff == STATUS_DONE && op_ff == OP_INSERT) begin
               count_next_ext = count_ext + CMPW'(1);
            end else if (status_ff == STATUS_DONE && op_ff == OP_DELETE) begin
               count_next_ext = cnt_m1;
            end
            if (slot_free) begin
               count_in      = count_next_ext[CW-1:0];
               rsp_valid_in  = 1'b1;
               rsp_value_in  = rd_hit_ff ? ram_rd_data : '0;
               rsp_status_in = status_ff;
               rsp_len_in    = count_next_ext[LEN_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      rd_hit_ff     <= rd_hit_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      addr_ff       <= addr_in;
      wr_addr_ff    <= wr_addr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
   end

   // ports
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_len_ff, rsp_value_ff});
   assign rsp_tuser  = rsp_status_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ext <= CMPW'(CAPACITY))
      else $error("entry count above capacity");

   a_count_only_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FINISH) |=> $stable(count_ff))
      else $error("entry count changed outside finish");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_FINISH))
      else $error("response register overwritten while pending");

   a_write_in_list: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (CMPW'(ram_wr_addr) <= count_ext))
      else $error("ram write beyond end of list");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SH_RD || state_ff == S_SH_WR || state_ff == S_PUT) |-> !req_tready)
      else $error("request taken during shift");

endmodule

// ----- tb/indexed_list_store_checker.sv -----
// indexed_list_store_checker: watches both streams of the list store and keeps its own copy
// of the list, predicts each response beat and compares it field by field
// depends on ils_pkg for op and status codes and beat field widths
module indexed_list_store_checker #(
   parameter int CAPACITY = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ils_pkg::REQ_DATA_W-1:0] req_tdata,   // position[6:0], value[38:7], zero pad
   input  logic [ils_pkg::REQ_USER_W-1:0] req_tuser,   // op[1:0]
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ils_pkg::RSP_DATA_W-1:0] rsp_tdata,   // read_value[31:0], length[38:32], zero pad
   input  logic [ils_pkg::RSP_USER_W-1:0] rsp_tuser,   // status[1:0]
   output int                             mismatch_count,
   output int                             pending_count
);
   import ils_pkg::*;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [STATUS_W-1:0]       status;
      logic [LEN_W-1:0]          length;
   } list_outcome_type;

   // model copy of the list contents and its length
   logic signed [VALUE_W-1:0] model_entries [CAPACITY];
   int unsigned               model_len;
   list_outcome_type          outcome_queue [$];

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // apply one operation to the model list and build the response it gives
   task automatic apply_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [VALUE_W-1:0] val,
                                output list_outcome_type res);
      int unsigned p;
      int unsigned i;
      p = pos;
      res = '0;
      res.status = STATUS_DONE;
      case (op)
         OP_READ: begin
            if (p >= model_len || p >= CAPACITY)
               res.status = STATUS_RANGE;
            else
               res.read_value = model_entries[p];
         end
         OP_INSERT: begin
            if (p > model_len) begin
               res.status = STATUS_RANGE;
            end else if (model_len >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               // open a gap at p, later entries move up one place
               for (i = model_len; i > p; i--)
                  model_entries[i] = model_entries[i-1];
               model_entries[p] = val;
               model_len++;
            end
         end
         OP_DELETE: begin
            if (p >= model_len || p >= CAPACITY) begin
               res.status = STATUS_RANGE;
            end else begin
               // close the gap, later entries move down one place
               for (i = p; i + 1 < model_len; i++)
                  model_entries[i] = model_entries[i+1];
               model_len--;
            end
         end
         default: ;  // unused code leaves the list alone
      endcase
      res.length = LEN_W'(model_len);
   endtask

   always @(posedge clock) begin
      list_outcome_type got;
      list_outcome_type want;
      list_outcome_type fresh;
      if (reset) begin
         model_len = 0;
         outcome_queue.delete();
      end else begin
         // response beat: compare with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.read_value = rsp_tdata[VALUE_W-1:0];
            got.length     = rsp_tdata[VALUE_W +: LEN_W];
            got.status     = rsp_tuser;
            if (outcome_queue.size() == 0) begin
               report_mismatch("response beat with no operation outstanding");
            end else begin
               want = outcome_queue.pop_front();
               if (got.read_value !== want.read_value)
                  report_mismatch($sformatf("read_value got %h want %h",
                                            got.read_value, want.read_value));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            got.status, want.status));
               if (got.length !== want.length)
                  report_mismatch($sformatf("length got %0d want %0d",
                                            got.length, want.length));
            end
         end
         // request beat: predict its response
         if (req_tvalid && req_tready) begin
            apply_list_op(req_tuser, req_tdata[POS_W-1:0], req_tdata[POS_W +: VALUE_W], fresh);
            outcome_queue.push_back(fresh);
         end
      end
      pending_count = outcome_queue.size();
   end

endmodule

// ----- tb/tb_indexed_list_store_top.sv -----
// tb_indexed_list_store_top: stimulus and verdict for indexed_list_store_top
// drives directed and random list operations with random idling on both streams,
// depends on ils_pkg, the block and indexed_list_store_checker
module tb_indexed_list_store_top;
   import ils_pkg::*;

   localparam int              CAPACITY     = 64;
   localparam int              RANDOM_OPS   = 1450;
   localparam int              DRAIN_CYCLES = 300;
   localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // position[6:0], value[38:7], zero pad
   logic [REQ_USER_W-1:0] req_tuser  = '0;   // op[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // read_value[31:0], length[38:32], zero pad
   logic [RSP_USER_W-1:0] rsp_tuser;         // status[1:0]
   int                    mismatch_count;
   int                    pending_count;

   // steering state: list length as seen from the stimulus side
   int  list_len;
   bit  calm_stretch;
   int  n_reads, n_inserts, n_deletes, n_unused, n_full, n_range;

   indexed_list_store_top #(.CAPACITY(CAPACITY)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   indexed_list_store_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   // clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // hard stop
   initial begin
      #8_000_000;
      $display("FAIL indexed_list_store_top");
      $finish;
   end

   function automatic int pick_gap();
      return calm_stretch ? 0 : $urandom_range(0, 8);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return '1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   // a position inside the current list, biased to head and tail
   function automatic logic [POS_W-1:0] pick_inside();
      if (list_len == 0)
         return '0;
      case ($urandom_range(0, 3))
         0: return '0;
         1: return POS_W'(list_len - 1);
         default: return POS_W'($urandom_range(0, list_len - 1));
      endcase
   endfunction

   // send one request beat, entered and left at a falling edge
   task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic [VALUE_W-1:0] val);
      int gap;
      int p;
      gap = pick_gap();
      p = pos;
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = op;
      req_tdata  = {1'b0, val, pos};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      // track the length for steering and the run summary
      case (op)
         OP_READ: begin
            n_reads++;
            if (p >= list_len) n_range++;
         end
         OP_INSERT: begin
            n_inserts++;
            if (p > list_len) n_range++;
            else if (list_len >= CAPACITY) n_full++;
            else list_len++;
         end
         OP_DELETE: begin
            n_deletes++;
            if (p >= list_len) n_range++;
            else list_len--;
         end
         default: n_unused++;
      endcase
   endtask

   task automatic random_op(input int ins_pct, input int del_pct);
      int                 r;
      logic [OP_W-1:0]    op;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] val;
      val = pick_value();
      r = $urandom_range(0, 99);
      if (r < 6) begin
         // noise: any code, any position
         op  = OP_W'($urandom_range(0, 3));
         pos = POS_W'($urandom_range(0, 127));
      end else begin
         r = $urandom_range(0, 99);
         if (r < ins_pct) begin
            op = OP_INSERT;
            case ($urandom_range(0, 3))
               0: pos = '0;
               1: pos = POS_W'(list_len);
               default: pos = POS_W'($urandom_range(0, list_len));
            endcase
         end else if (r < ins_pct + del_pct) begin
            op  = OP_DELETE;
            pos = pick_inside();
         end else begin
            op  = OP_READ;
            pos = pick_inside();
         end
      end
      send_op(op, pos, val);
   endtask

   // response side: random stall before each beat
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = pick_gap();
         rsp_tready = (stall == 0);
         repeat (stall) @(negedge clock);
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      int sent;
      int phase_len;
      int ins_pct;
      int del_pct;
      list_len = 0;
      calm_stretch = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty list, head, tail and middle inserts, range rejects, unused code
      send_op(OP_READ,   7'd0,   32'h0);
      send_op(OP_DELETE, 7'd0,   32'h0);
      send_op(OP_INSERT, 7'd1,   32'h1234_5678);
      send_op(OP_INSERT, 7'd0,   32'h8000_0000);
      send_op(OP_INSERT, 7'd1,   32'h7fff_ffff);
      send_op(OP_INSERT, 7'd0,   32'hffff_ffff);
      send_op(OP_INSERT, 7'd2,   32'h0);
      for (int i = 0; i < 4; i++)
         send_op(OP_READ, POS_W'(i), 32'hffff_ffff);
      send_op(OP_READ,   7'd4,   32'h0);
      send_op(OP_READ,   7'd64,  32'h0);
      send_op(OP_READ,   7'd127, 32'h0);
      send_op(OP_INSERT, 7'd127, 32'haaaa_aaaa);
      send_op(OP_INSERT, 7'd5,   32'h5555_5555);
      send_op(OP_DELETE, 7'd4,   32'h0);
      send_op(OP_DELETE, 7'd127, 32'h0);
      send_op(OP_UNUSED, 7'd127, 32'hffff_ffff);
      send_op(OP_UNUSED, 7'd0,   32'h0);
      send_op(OP_DELETE, 7'd1,   32'h0);
      send_op(OP_READ,   7'd1,   32'h0);
      send_op(OP_DELETE, 7'd2,   32'h0);
      send_op(OP_DELETE, 7'd0,   32'h0);
      send_op(OP_READ,   7'd0,   32'h0);
      send_op(OP_DELETE, 7'd0,   32'h0);

      // fill to capacity, then push against the full store
      sent = 0;
      while (list_len < CAPACITY) begin
         random_op(90, 5);
         sent++;
      end
      repeat (4) begin
         random_op(100, 0);
         sent++;
      end
      send_op(OP_INSERT, 7'd64, pick_value());
      sent++;

      // random phases: growing, shrinking and mixed, some without idling
      while (sent < RANDOM_OPS) begin
         calm_stretch = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(30, 120);
         case ($urandom_range(0, 2))
            0: begin ins_pct = 70; del_pct = 15; end
            1: begin ins_pct = 15; del_pct = 70; end
            default: begin ins_pct = 35; del_pct = 35; end
         endcase
         repeat (phase_len) begin
            random_op(ins_pct, del_pct);
            sent++;
         end
      end
      req_tvalid = 1'b0;
      calm_stretch = 1'b0;

      // drain
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d reads, %0d inserts, %0d deletes, %0d unused codes",
               n_reads, n_inserts, n_deletes, n_unused);
      $display("run: %0d full-store inserts, %0d out-of-range positions, %0d mismatches",
               n_full, n_range, mismatch_count);
      if (mismatch_count == 0)
         $display("PASS indexed_list_store_top");
      else
         $display("FAIL indexed_list_store_top");
      $finish;
   end

endmodule
